// File: rtl/core/assert_macros.svh
// Assertion macros shared by the priority queue RTL.
// Depends on nothing; included by the modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/spq_pkg.sv
// Types and constants of the sorted priority queue.
// No dependencies; used by spq_ctrl, spq_datapath and sorted_priority_queue.
package spq_pkg;

  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int FILL_W   = 4;
  localparam int IN_W     = 40;  // cmd + value, padded to whole bytes
  localparam int OUT_W    = 40;  // status + head + fill, padded to whole bytes

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ENQ,
    OP_DEQ
  } op_t;

  // Controller to datapath.
  typedef struct packed {
    op_t  op;    // update applied to the stored entries
    logic load;  // capture head value (zero unless dequeuing) and fill count into the result word
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic full;
    logic empty;
  } dp_stat_t;

endpackage

// File: rtl/core/spq_datapath.sv
// Datapath of the sorted priority queue: entry cells, fill count, order bit.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_datapath #(
  parameter int CAPACITY = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic                                cfg_wr_data,
  input  spq_pkg::dp_cmd_t                    cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0]  value,
  output spq_pkg::dp_stat_t                   stat,
  output logic signed [spq_pkg::VALUE_W-1:0]  head_value,
  output logic [spq_pkg::FILL_W-1:0]          fill_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int FW = spq_pkg::FILL_W;
  localparam int VW = spq_pkg::VALUE_W;

  logic signed [VW-1:0] entry_r [CAPACITY];
  logic signed [VW-1:0] entry_nxt [CAPACITY];
  logic [CW-1:0]        count_r, count_nxt;
  logic                 asc_r;
  logic signed [VW-1:0] head_r;
  logic [FW-1:0]        fill_r;

  logic [CAPACITY-1:0]  in_range;   // slot holds a stored entry
  logic [CAPACITY-1:0]  behind;     // stored entry must move behind the new value
  logic [CAPACITY:0]    sfx;        // every stored entry from this slot up moves
  logic [CAPACITY-1:0]  shift_in;
  logic [CAPACITY-1:0]  take_new;

  assign stat.full  = (count_r == CW'(CAPACITY));
  assign stat.empty = (count_r == '0);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      in_range[i] = (CW'(i) < count_r);
      behind[i]   = asc_r ? (entry_r[i] > value) : (entry_r[i] < value);
    end
    sfx[CAPACITY] = 1'b1;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      sfx[i] = (behind[i] | ~in_range[i]) & sfx[i + 1];
    end
    shift_in[0] = 1'b0;
    for (int i = 1; i < CAPACITY; i++) begin
      shift_in[i] = in_range[i - 1] & sfx[i - 1];
    end
    for (int i = 0; i < CAPACITY; i++) begin
      take_new[i] = (CW'(i) <= count_r) & ~shift_in[i] & sfx[i];
    end
  end

  always_comb begin
    count_nxt = count_r;
    for (int i = 0; i < CAPACITY; i++) begin
      entry_nxt[i] = entry_r[i];
    end
    case (cmd.op)
      spq_pkg::OP_ENQ: begin
        count_nxt = count_r + CW'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (take_new[i]) begin
            entry_nxt[i] = value;
          end
        end
        for (int i = 1; i < CAPACITY; i++) begin
          if (shift_in[i]) begin
            entry_nxt[i] = entry_r[i - 1];
          end
        end
      end
      spq_pkg::OP_DEQ: begin
        count_nxt = count_r - CW'(1);
        for (int i = 0; i < CAPACITY - 1; i++) begin
          entry_nxt[i] = entry_r[i + 1];
        end
      end
      default: begin
      end
    endcase
  end

  // Entry cells and result payload registers: no reset.
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      entry_r[i] <= entry_nxt[i];
    end
    if (cmd.load) begin
      head_r <= (cmd.op == spq_pkg::OP_DEQ) ? entry_r[0] : '0;
      fill_r <= FW'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      asc_r   <= 1'b1;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        asc_r <= cfg_wr_data;
      end
    end
  end

  assign head_value = head_r;
  assign fill_count = fill_r;

  `SPQ_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY), "count past capacity")
  `SPQ_ASSERT_NXT(a_enq_grows, clk, rst_n, cmd.op == spq_pkg::OP_ENQ, count_r == $past(count_r) + CW'(1), "enqueue did not grow count")

endmodule

// File: rtl/core/spq_ctrl.sv
// Controller of the sorted priority queue: handshake, op decode, status.
// Depends on spq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module spq_ctrl (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic                              in_cmd,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [spq_pkg::STATUS_W-1:0]      out_status,
  output spq_pkg::dp_cmd_t                  cmd,
  input  spq_pkg::dp_stat_t                 stat
);

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_t;

  state_t                         state_r, state_nxt;
  logic [spq_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                           accept;

  // Take a word whenever the result register is empty or drains this cycle.
  assign in_tready = (state_r == S_IDLE) || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    cmd.op     = spq_pkg::OP_NONE;
    cmd.load   = accept;
    status_nxt = status_r;
    if (accept) begin
      if (in_cmd == spq_pkg::CMD_ENQ) begin
        cmd.op     = stat.full ? spq_pkg::OP_NONE : spq_pkg::OP_ENQ;
        status_nxt = stat.full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
      end else begin
        cmd.op     = stat.empty ? spq_pkg::OP_NONE : spq_pkg::OP_DEQ;
        status_nxt = stat.empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_DONE;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  state_nxt = accept ? S_HOLD : S_IDLE;
      S_HOLD:  state_nxt = (out_tready && !accept) ? S_IDLE : S_HOLD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      status_r <= spq_pkg::ST_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_tvalid = (state_r == S_HOLD);
  assign out_status = status_r;

  `SPQ_ASSERT_NXT(a_accept_shows, clk, rst_n, accept, out_tvalid, "accepted word not presented")
  `SPQ_ASSERT_NXT(a_full_reject, clk, rst_n, accept && in_cmd == spq_pkg::CMD_ENQ && stat.full, status_r == spq_pkg::ST_FULL, "full enqueue not rejected")
  `SPQ_ASSERT_IMP(a_no_op_rejected, clk, rst_n, accept && stat.full && in_cmd == spq_pkg::CMD_ENQ, cmd.op == spq_pkg::OP_NONE, "rejected enqueue changed entries")

endmodule

// File: rtl/core/sorted_priority_queue.sv
// Sorted priority queue: one result word per input word, registered output.
// Result valid in the cycle after input accept; throughput 1 word/cycle while out_tready stays high.
// Insert is done by per-slot compare-and-shift cells; the order
// compare and tail-to-head shift chain across the cells sets the cycle time.
// Reset (rst_n low, synchronous) empties the queue, selects ascending order
// and drops any pending result; entry contents are not cleared.
module sorted_priority_queue #(
  parameter int CAPACITY = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration: bit 0 is ascending_order.
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  // Input word.
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [spq_pkg::IN_W-1:0]     in_tdata,   // [0] cmd, [32:1] value, [39:33] zero
  // Result word.
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [spq_pkg::OUT_W-1:0]    out_tdata   // [1:0] status, [33:2] head_value,
                                                   // [37:34] fill_count, [39:38] zero
);

  localparam int VW = spq_pkg::VALUE_W;
  localparam int SW = spq_pkg::STATUS_W;
  localparam int FW = spq_pkg::FILL_W;

  spq_pkg::dp_cmd_t          dp_cmd;
  spq_pkg::dp_stat_t         dp_stat;
  logic                      in_cmd;
  logic signed [VW-1:0]      in_value;
  logic [SW-1:0]             res_status;
  logic signed [VW-1:0]      res_head;
  logic [FW-1:0]             res_fill;

  // Unpack the input word; the pad bits carry nothing.
  assign in_cmd   = in_tdata[0];
  assign in_value = in_tdata[VW:1];

  // Controller: accept words, decode full/empty rejections, hold the
  // result valid until the sink takes it.
  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (res_status),
    .cmd        (dp_cmd),
    .stat       (dp_stat)
  );

  // Datapath: sorted entry cells, fill count, order bit, result payload.
  spq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (dp_cmd),
    .value       (in_value),
    .stat        (dp_stat),
    .head_value  (res_head),
    .fill_count  (res_fill)
  );

  // Pack the result word, status in the low bits.
  assign out_tdata = {{(spq_pkg::OUT_W - SW - VW - FW){1'b0}}, res_fill, res_head, res_status};

endmodule
